FILE: rtl/acwp_pkg.sv
package acwp_pkg;

	localparam int MAX_TILES_DEF   = 32;
	localparam int WEIGHT_BITS_DEF = 8;
	localparam int COUNT_W         = 6;
	localparam int RAND_W          = 32;
	localparam int ROW_W           = 32;
	localparam int IDX_W           = 5;
	localparam int WIN_W           = 8;
	localparam int ACT_W           = 2;

	localparam logic [ACT_W-1:0] ACT_PICK   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_RIGHT  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_DOWN   = 2'd2;
	localparam logic [ACT_W-1:0] ACT_WEIGHT = 2'd3;

	typedef struct packed {
		logic load;
		logic scan_clr;
		logic scan_step;
		logic mod_start;
		logic sel_clr;
		logic sel_step;
	} acwp_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic mod_done;
		logic sel_done;
		logic is_pick;
	} acwp_sts_t;

endpackage

FILE: rtl/acwp_in_if.sv
interface acwp_in_if;
	logic                              valid;
	logic                              ready;
	logic [acwp_pkg::ACT_W-1:0]        action;
	logic [acwp_pkg::IDX_W-1:0]        tile_index;
	logic [acwp_pkg::ROW_W-1:0]        row_bits;
	logic [acwp_pkg::WIN_W-1:0]        weight_value;
	logic                              has_left;
	logic [acwp_pkg::IDX_W-1:0]        left_tile;
	logic                              has_top;
	logic [acwp_pkg::IDX_W-1:0]        top_tile;
	logic [acwp_pkg::RAND_W-1:0]       random_word;

	modport source (output valid, action, tile_index, row_bits, weight_value, has_left,
		left_tile, has_top, top_tile, random_word, input ready);
	modport sink (input valid, action, tile_index, row_bits, weight_value, has_left,
		left_tile, has_top, top_tile, random_word, output ready);
endinterface

FILE: rtl/acwp_out_if.sv
interface acwp_out_if;
	logic                              valid;
	logic                              ready;
	logic                              found;
	logic [acwp_pkg::IDX_W-1:0]        chosen_tile;
	logic [acwp_pkg::COUNT_W-1:0]      candidate_count;

	modport source (output valid, found, chosen_tile, candidate_count, input ready);
	modport sink (input valid, found, chosen_tile, candidate_count, output ready);
endinterface

FILE: rtl/acwp_mod.sv
module acwp_mod (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] remainder
);

	logic [31:0] quo_q;
	logic [32:0] rem_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [32:0] trial;

	assign trial     = {rem_q[31:0], quo_q[31]} - {1'b0, divisor};
	assign remainder = rem_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[30:0], 1'b0};
			if (!trial[32]) rem_q <= trial;
			else rem_q <= {rem_q[31:0], quo_q[31]};
		end
	end

endmodule

FILE: rtl/acwp_datapath.sv
module acwp_datapath #(
	parameter int MAX_TILES   = acwp_pkg::MAX_TILES_DEF,
	parameter int WEIGHT_BITS = acwp_pkg::WEIGHT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  acwp_pkg::acwp_cmd_t           cmd,
	output acwp_pkg::acwp_sts_t           sts,
	input  logic [acwp_pkg::COUNT_W-1:0]  tile_count,
	acwp_in_if.sink                       in_ch,
	output logic                          found,
	output logic [acwp_pkg::IDX_W-1:0]    chosen_tile,
	output logic [acwp_pkg::COUNT_W-1:0]  candidate_count
);

	localparam int TI_W  = $clog2(MAX_TILES);
	localparam int CNT_W = $clog2(MAX_TILES + 1);
	localparam int TOT_W = WEIGHT_BITS + TI_W + 1;

	logic [MAX_TILES-1:0]   right_q [MAX_TILES];
	logic [MAX_TILES-1:0]   down_q  [MAX_TILES];
	logic [WEIGHT_BITS-1:0] wt_q    [MAX_TILES];

	logic [MAX_TILES-1:0]   cand_q;
	logic [31:0]            rnd_q;
	logic [TI_W-1:0]        t_q;
	logic [CNT_W-1:0]       count_q;
	logic [TOT_W-1:0]       total_q;
	logic [TOT_W-1:0]       accum_q;
	logic [TOT_W-1:0]       target_q;
	logic                   is_pick_q;
	logic                   hit_q;
	logic                   mod_done;
	logic [31:0]            rem;
	logic [MAX_TILES-1:0]   mask;
	logic [MAX_TILES-1:0]   row_bits_m;
	logic [MAX_TILES-1:0]   lrow;
	logic [MAX_TILES-1:0]   trow;
	logic                   uni;
	logic                   cur;
	logic [WEIGHT_BITS-1:0] cur_w;
	logic [TOT_W-1:0]       acc_nx;
	logic [TI_W:0]          ti_ext;

	always_comb begin
		for (int i = 0; i < MAX_TILES; i++)
			mask[i] = (32'(i) < 32'(tile_count));
		for (int i = 0; i < MAX_TILES; i++)
			row_bits_m[i] = (i < acwp_pkg::ROW_W) ? in_ch.row_bits[i % acwp_pkg::ROW_W] : 1'b0;
		lrow = (32'(in_ch.left_tile) < 32'(MAX_TILES))
			? right_q[TI_W'(in_ch.left_tile)] : '0;
		trow = (32'(in_ch.top_tile) < 32'(MAX_TILES))
			? down_q[TI_W'(in_ch.top_tile)] : '0;
	end

	assign ti_ext = {1'b0, t_q};
	assign uni    = (total_q == '0);
	assign cur    = cand_q[t_q];
	assign cur_w  = wt_q[t_q];
	assign acc_nx = uni ? accum_q + TOT_W'(1) : accum_q + TOT_W'(cur_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TILES; i++) begin
				right_q[i] <= '0;
				down_q[i]  <= '0;
				wt_q[i]    <= '0;
			end
		end else if (cmd.load && in_ch.action != acwp_pkg::ACT_PICK
			&& 32'(in_ch.tile_index) < 32'(MAX_TILES)) begin
			case (in_ch.action)
				acwp_pkg::ACT_RIGHT:  right_q[TI_W'(in_ch.tile_index)] <= row_bits_m;
				acwp_pkg::ACT_DOWN:   down_q[TI_W'(in_ch.tile_index)]  <= row_bits_m;
				acwp_pkg::ACT_WEIGHT:
					wt_q[TI_W'(in_ch.tile_index)] <= WEIGHT_BITS'(in_ch.weight_value);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			is_pick_q <= (in_ch.action == acwp_pkg::ACT_PICK);
			rnd_q     <= in_ch.random_word;
			cand_q    <= mask & (in_ch.has_left ? lrow : '1) & (in_ch.has_top ? trow : '1);
		end
		if (cmd.scan_clr) begin
			t_q     <= '0;
			count_q <= '0;
			total_q <= '0;
		end else if (cmd.scan_step) begin
			t_q <= t_q + TI_W'(1);
			if (cur) begin
				count_q <= count_q + CNT_W'(1);
				total_q <= total_q + TOT_W'(cur_w);
			end
		end
		if (mod_done) target_q <= uni ? TOT_W'(rem) : TOT_W'(rem) + TOT_W'(1);
		if (cmd.sel_clr) begin
			t_q     <= '0;
			accum_q <= '0;
			hit_q   <= 1'b0;
		end else if (cmd.sel_step && !hit_q) begin
			t_q <= t_q + TI_W'(1);
			if (cur && (uni || cur_w != '0)) begin
				accum_q <= acc_nx;
				if (uni ? (target_q == accum_q) : (target_q <= acc_nx)) begin
					hit_q       <= 1'b1;
					chosen_tile <= acwp_pkg::IDX_W'(ti_ext);
				end
			end
		end
		if (cmd.scan_clr) chosen_tile <= '0;
	end

	acwp_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.mod_start),
		.dividend  (rnd_q),
		.divisor   (uni ? 32'(count_q) : 32'(total_q)),
		.done      (mod_done),
		.remainder (rem)
	);

	assign found           = (count_q != '0);
	assign candidate_count = (32'(count_q) > 63) ? 6'd63 : acwp_pkg::COUNT_W'(count_q);
	assign sts.scan_last   = (32'(t_q) == MAX_TILES - 1);
	assign sts.mod_done    = mod_done;
	assign sts.sel_done    = hit_q || (32'(t_q) == MAX_TILES - 1 && cmd.sel_step);
	assign sts.is_pick     = is_pick_q;

endmodule

FILE: rtl/acwp_ctrl.sv
module acwp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  logic                any_cand,
	input  acwp_pkg::acwp_sts_t sts,
	output acwp_pkg::acwp_cmd_t cmd
);

	typedef enum logic [2:0] {IDLE, DECODE, SCAN, MODW, SEL, OUT} state_t;
	state_t state_q;

	assign in_ready = (state_q == IDLE);

	always_comb begin
		cmd           = '0;
		cmd.load      = in_valid && in_ready;
		cmd.scan_clr  = (state_q == DECODE);
		cmd.scan_step = (state_q == SCAN);
		cmd.mod_start = (state_q == SCAN) && sts.scan_last;
		cmd.sel_clr   = (state_q == MODW);
		cmd.sel_step  = (state_q == SEL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= IDLE;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				IDLE:   if (in_valid) state_q <= DECODE;
				DECODE: state_q <= sts.is_pick ? SCAN : IDLE;
				SCAN:   if (sts.scan_last) state_q <= MODW;
				MODW:   if (sts.mod_done) begin
					if (any_cand) state_q <= SEL;
					else begin
						state_q   <= OUT;
						out_valid <= 1'b1;
					end
				end
				SEL:    if (sts.sel_done) begin
					state_q   <= OUT;
					out_valid <= 1'b1;
				end
				OUT:    if (out_ready) begin
					state_q   <= IDLE;
					out_valid <= 1'b0;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/adjacency_constrained_weighted_pick_top.sv
// Roulette-wheel tile picker under adjacency constraints. Load items write one
// right row, down row or weight and give no result. A pick item runs a
// candidate and weight scan, a bit-serial modulo and, if any tile is a
// candidate, a cumulative select, and gives one result; items are handled
// one at a time.
module adjacency_constrained_weighted_pick_top #(
	parameter int MAX_TILES   = acwp_pkg::MAX_TILES_DEF,
	parameter int WEIGHT_BITS = acwp_pkg::WEIGHT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [acwp_pkg::COUNT_W-1:0]  cfg_wdata,
	acwp_in_if.sink                       in_ch,
	acwp_out_if.source                    out_ch
);

	localparam int CNT_W = $clog2(MAX_TILES + 1);

	logic [acwp_pkg::COUNT_W-1:0] tile_count_q;
	logic [acwp_pkg::COUNT_W-1:0] eff_count;
	acwp_pkg::acwp_cmd_t          cmd;
	acwp_pkg::acwp_sts_t          sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tile_count_q <= '0;
		else if (cfg_we) tile_count_q <= cfg_wdata;
	end

	assign eff_count = (32'(tile_count_q) > MAX_TILES)
		? acwp_pkg::COUNT_W'(CNT_W'(MAX_TILES)) : tile_count_q;

	acwp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.any_cand  (out_ch.found),
		.sts       (sts),
		.cmd       (cmd)
	);

	acwp_datapath #(
		.MAX_TILES   (MAX_TILES),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.tile_count      (eff_count),
		.in_ch           (in_ch),
		.found           (out_ch.found),
		.chosen_tile     (out_ch.chosen_tile),
		.candidate_count (out_ch.candidate_count)
	);

`ifndef ASSERT_OFF
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !in_ch.ready) else $error("input taken while result pending");
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.found) |-> (out_ch.chosen_tile == '0))
		else $error("tile reported without candidates");
	a_start_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mod_start |=> !cmd.mod_start) else $error("modulo restarted");
`endif

endmodule

FILE: tb/sv/tb_adjacency_constrained_weighted_pick_top.sv
`timescale 1ns / 100ps

module tb_adjacency_constrained_weighted_pick_top;

	localparam int  NT        = acwp_pkg::MAX_TILES_DEF;
	localparam int  LIMIT     = 3000000;
	localparam int  SETTLE    = 200;

	typedef struct {
		logic [acwp_pkg::ACT_W-1:0]   action;
		logic [acwp_pkg::IDX_W-1:0]   tile_index;
		logic [acwp_pkg::ROW_W-1:0]   row_bits;
		logic [acwp_pkg::WIN_W-1:0]   weight_value;
		logic                         has_left;
		logic [acwp_pkg::IDX_W-1:0]   left_tile;
		logic                         has_top;
		logic [acwp_pkg::IDX_W-1:0]   top_tile;
		logic [acwp_pkg::RAND_W-1:0]  random_word;
	} tile_req_t;

	typedef struct {
		logic                         found;
		logic [acwp_pkg::IDX_W-1:0]   chosen_tile;
		logic [acwp_pkg::COUNT_W-1:0] candidate_count;
	} pick_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [acwp_pkg::COUNT_W-1:0] cfg_wdata = '0;

	acwp_in_if  in_ch();
	acwp_out_if out_ch();

	adjacency_constrained_weighted_pick_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	always #4 clk = ~clk;

	tile_req_t   pending_q[$];
	pick_res_t   picks_due_q[$];
	logic [acwp_pkg::ROW_W-1:0] right_tab[NT];
	logic [acwp_pkg::ROW_W-1:0] down_tab[NT];
	logic [acwp_pkg::WIN_W-1:0] weight_tab[NT];
	logic [acwp_pkg::COUNT_W-1:0] tiles_in_use = '0;
	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	int  hold_cycles = 0;
	int  n_queued = 0;
	int  n_taken = 0;
	int  n_errors = 0;
	int  n_cycles = 0;
	logic took = 1'b0;

	initial begin
		for (int i = 0; i < NT; i++) begin
			right_tab[i] = '0;
			down_tab[i] = '0;
			weight_tab[i] = '0;
		end
		in_ch.valid = 1'b0;
		in_ch.action = acwp_pkg::ACT_PICK;
		in_ch.tile_index = '0;
		in_ch.row_bits = '0;
		in_ch.weight_value = '0;
		in_ch.has_left = 1'b0;
		in_ch.left_tile = '0;
		in_ch.has_top = 1'b0;
		in_ch.top_tile = '0;
		in_ch.random_word = '0;
		out_ch.ready = 1'b0;
	end

	function automatic pick_res_t predict_pick(tile_req_t r);
		pick_res_t res;
		logic [acwp_pkg::ROW_W-1:0] cand;
		int n_use, cnt, total, target, accum;
		res.found = 1'b0;
		res.chosen_tile = '0;
		n_use = (tiles_in_use > NT) ? NT : int'(tiles_in_use);
		cand = (n_use >= 32) ? '1 : ((32'd1 << n_use) - 32'd1);
		if (r.has_left)
			cand &= right_tab[r.left_tile];
		if (r.has_top)
			cand &= down_tab[r.top_tile];
		cnt = 0;
		total = 0;
		for (int t = 0; t < NT; t++) begin
			if (cand[t]) begin
				cnt++;
				total += weight_tab[t];
			end
		end
		accum = 0;
		if (cnt != 0) begin
			res.found = 1'b1;
			if (total == 0) begin
				target = int'({32'd0, r.random_word} % cnt);
				for (int t = 0; t < NT; t++) begin
					if (cand[t]) begin
						if (accum == target) begin
							res.chosen_tile = acwp_pkg::IDX_W'(t);
							break;
						end
						accum++;
					end
				end
			end else begin
				target = int'({32'd0, r.random_word} % total) + 1;
				for (int t = 0; t < NT; t++) begin
					if (cand[t] && weight_tab[t] != 0) begin
						accum += weight_tab[t];
						if (target <= accum) begin
							res.chosen_tile = acwp_pkg::IDX_W'(t);
							break;
						end
					end
				end
			end
		end
		res.candidate_count = (cnt > 63) ? 6'd63 : cnt[acwp_pkg::COUNT_W-1:0];
		return res;
	endfunction

	function automatic tile_req_t mk_req(logic [acwp_pkg::ACT_W-1:0] act, int idx,
			logic [31:0] row, int wt, bit hl, int lt, bit ht, int tt, logic [31:0] rnd);
		tile_req_t r;
		r.action = act;
		r.tile_index = acwp_pkg::IDX_W'(idx);
		r.row_bits = row;
		r.weight_value = acwp_pkg::WIN_W'(wt);
		r.has_left = hl;
		r.left_tile = acwp_pkg::IDX_W'(lt);
		r.has_top = ht;
		r.top_tile = acwp_pkg::IDX_W'(tt);
		r.random_word = rnd;
		return r;
	endfunction

	function automatic tile_req_t rand_req(int pick_pct);
		tile_req_t r;
		logic [31:0] rnd;
		int sel;
		sel = $urandom_range(99);
		case ($urandom_range(3))
			0: rnd = $urandom_range(15);
			1: rnd = 32'hFFFF_FFFF - $urandom_range(15);
			default: rnd = $urandom;
		endcase
		r = mk_req(acwp_pkg::ACT_PICK, $urandom_range(31), $urandom, $urandom_range(255),
			$urandom_range(1), $urandom_range(31), $urandom_range(1), $urandom_range(31), rnd);
		if (sel >= pick_pct) begin
			case ($urandom_range(2))
				0: r.action = acwp_pkg::ACT_RIGHT;
				1: r.action = acwp_pkg::ACT_DOWN;
				default: r.action = acwp_pkg::ACT_WEIGHT;
			endcase
			if ($urandom_range(3) == 0)
				r.weight_value = '0;
			if ($urandom_range(5) == 0)
				r.row_bits = '1;
			else if ($urandom_range(5) == 0)
				r.row_bits = '0;
		end
		return r;
	endfunction

	task automatic queue_req(tile_req_t r);
		pending_q.insert(pending_q.size(), r);
		n_queued++;
	endtask

	task automatic drain;
		wait (n_taken == n_queued && picks_due_q.size() == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_tile_count(logic [acwp_pkg::COUNT_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		tiles_in_use = v;
	endtask

	always @(posedge clk) begin
		took <= in_ch.valid && in_ch.ready;
		if (in_ch.valid && in_ch.ready) begin
			tile_req_t r;
			r.action = in_ch.action;
			r.tile_index = in_ch.tile_index;
			r.row_bits = in_ch.row_bits;
			r.weight_value = in_ch.weight_value;
			r.has_left = in_ch.has_left;
			r.left_tile = in_ch.left_tile;
			r.has_top = in_ch.has_top;
			r.top_tile = in_ch.top_tile;
			r.random_word = in_ch.random_word;
			n_taken++;
			case (r.action)
				acwp_pkg::ACT_PICK:   picks_due_q.insert(picks_due_q.size(), predict_pick(r));
				acwp_pkg::ACT_RIGHT:  right_tab[r.tile_index] = r.row_bits;
				acwp_pkg::ACT_DOWN:   down_tab[r.tile_index] = r.row_bits;
				acwp_pkg::ACT_WEIGHT: weight_tab[r.tile_index] = r.weight_value;
				default: ;
			endcase
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!in_ch.valid || took)) begin
			if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				tile_req_t r;
				r = pending_q.pop_front();
				in_ch.action <= r.action;
				in_ch.tile_index <= r.tile_index;
				in_ch.row_bits <= r.row_bits;
				in_ch.weight_value <= r.weight_value;
				in_ch.has_left <= r.has_left;
				in_ch.left_tile <= r.left_tile;
				in_ch.has_top <= r.has_top;
				in_ch.top_tile <= r.top_tile;
				in_ch.random_word <= r.random_word;
				in_ch.valid <= 1'b1;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (hold_cycles > 0)
			hold_cycles <= hold_cycles - 1;
	end

	always @(negedge clk) begin
		if (!arst_n || hold_cycles > 0)
			out_ch.ready <= 1'b0;
		else
			out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (out_ch.valid && out_ch.ready) begin
			if (picks_due_q.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("unexpected result: found=%0d tile=%0d count=%0d",
						out_ch.found, out_ch.chosen_tile, out_ch.candidate_count);
			end else begin
				pick_res_t e;
				e = picks_due_q.pop_front();
				if (out_ch.found !== e.found || out_ch.chosen_tile !== e.chosen_tile ||
						out_ch.candidate_count !== e.candidate_count) begin
					n_errors++;
					if (n_errors <= 10)
						$display("mismatch: exp found=%0d tile=%0d count=%0d, got %0d %0d %0d",
							e.found, e.chosen_tile, e.candidate_count, out_ch.found,
							out_ch.chosen_tile, out_ch.candidate_count);
				end
			end
		end
	end

	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles >= LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		logic [acwp_pkg::COUNT_W-1:0] counts[8];
		counts = '{6'd32, 6'd0, 6'd63, 6'd1, 6'd17, 6'd33, 6'd2, 6'd32};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_tile_count(6'd32);
		// reset tables: all weights zero, uniform pick
		queue_req(mk_req(acwp_pkg::ACT_PICK, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
		queue_req(mk_req(acwp_pkg::ACT_PICK, 0, 0, 0, 1, 5, 0, 0, 32'h0));
		queue_req(mk_req(acwp_pkg::ACT_RIGHT, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0));
		queue_req(mk_req(acwp_pkg::ACT_DOWN, 31, 32'h8000_0001, 0, 0, 0, 0, 0, 0));
		queue_req(mk_req(acwp_pkg::ACT_PICK, 0, 0, 0, 1, 0, 1, 31, 32'h1));
		queue_req(mk_req(acwp_pkg::ACT_WEIGHT, 31, 0, 255, 0, 0, 0, 0, 0));
		queue_req(mk_req(acwp_pkg::ACT_WEIGHT, 0, 0, 0, 0, 0, 0, 0, 0));
		queue_req(mk_req(acwp_pkg::ACT_WEIGHT, 5, 0, 1, 0, 0, 0, 0, 0));
		queue_req(mk_req(acwp_pkg::ACT_PICK, 0, 0, 0, 0, 0, 0, 0, 32'h0));
		queue_req(mk_req(acwp_pkg::ACT_PICK, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
		queue_req(mk_req(acwp_pkg::ACT_PICK, 0, 0, 0, 0, 0, 0, 0, 32'd255));
		queue_req(mk_req(acwp_pkg::ACT_PICK, 0, 0, 0, 1, 0, 1, 31, 32'd255));
		queue_req(mk_req(acwp_pkg::ACT_PICK, 0, 0, 0, 1, 3, 0, 0, 32'h1234_5678));
		queue_req(mk_req(acwp_pkg::ACT_PICK, 0, 0, 0, 0, 0, 1, 31, 32'hFFFF_FFFE));
		queue_req(mk_req(acwp_pkg::ACT_RIGHT, 31, 32'h0000_0001, 0, 0, 0, 0, 0, 0));
		queue_req(mk_req(acwp_pkg::ACT_PICK, 0, 0, 0, 1, 31, 1, 31, 32'h7));
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
				default: begin send_idle_pct = 16; recv_stall_pct = 16; end
			endcase
			if (ph == 7)
				set_tile_count(acwp_pkg::COUNT_W'($urandom_range(63)));
			else
				set_tile_count(counts[ph]);
			if (ph == 4)
				hold_cycles = 3000;
			for (int i = 0; i < 136; i++)
				queue_req(rand_req((i < 40) ? 20 : 65));
			drain();
		end

		if (n_errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
